>>> design/kep_pkg.sv
// Shared types, constants and saturating helpers for the Euler orbit step block.
package kep_pkg;

  // Fixed point format of all state and result words.
  localparam int FRAC_BITS  = 16;
  localparam int WORD_WIDTH = 32;

  // Configuration register indexes.
  localparam logic [2:0] REG_INIT_POS_X   = 3'd0;
  localparam logic [2:0] REG_INIT_POS_Y   = 3'd1;
  localparam logic [2:0] REG_INIT_VEL_X   = 3'd2;
  localparam logic [2:0] REG_INIT_VEL_Y   = 3'd3;
  localparam logic [2:0] REG_GRAVITY      = 3'd4;
  localparam logic [2:0] REG_CENTRAL_MASS = 3'd5;

  // Request opcodes.
  localparam logic OP_STEP   = 1'b0;
  localparam logic OP_RELOAD = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [30:0] time_step;
  } kep_cmd_t;

  typedef struct packed {
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;
    logic signed [31:0] energy_out;
    logic               singular;
  } kep_res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_GM, ST_GMSV, ST_RSQX, ST_RSQY, ST_RSUM, ST_SQRT, ST_RDONE,
    ST_DIV, ST_G2, ST_GSV, ST_MH, ST_ML, ST_MS, ST_MW,
    ST_UPX, ST_UPXW, ST_UPYW, ST_UVXW, ST_UVYW,
    ST_PEW, ST_KEX, ST_KEY, ST_KES, ST_FIN
  } kep_state_t;

  // Magnitude of a signed word; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    logic [31:0] u;
    u = a;
    return a[31] ? (32'd0 - u) : u;
  endfunction

  // Apply a sign to a 64-bit magnitude and saturate to the signed word.
  function automatic logic signed [31:0] to_word(input logic neg, input logic [63:0] m);
    logic big;
    big = (m > 64'h0000_0000_7FFF_FFFF);
    if (!neg) begin
      return big ? 32'sh7FFF_FFFF : $signed(m[31:0]);
    end
    return big ? 32'sh8000_0000 : $signed(32'd0 - m[31:0]);
  endfunction

  // Saturating signed word addition.
  function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s > 33'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end
    if (s < -33'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

endpackage

>>> design/kepler_orbit_euler_step.sv
// Top level of the explicit Euler two-body orbit integrator with its sequencer.
// A step request runs two square roots and five bit-serial quotients, a reload request
// one of each, from acceptance to the result being offered; a zero radius skips its divisions.
// cmd_stall holds off a new request until the sequencer is back in idle, so one request
// finishes before the next is taken, and the wait is longer while a result waits on the receiver.
// Reset (rst, synchronous) loads the state with position (1.0, 0) and velocity (0, 1.0).
module kepler_orbit_euler_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  kep_pkg::kep_cmd_t   cmd,
  output logic                res_valid,
  input  logic                res_stall,
  output kep_pkg::kep_res_t   res,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import kep_pkg::*;

  localparam logic [5:0] DIV_LAST  = 6'd63;
  localparam logic [5:0] SQRT_LAST = 6'd31;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  kep_state_t state, state_next, div_ret;
  logic [5:0] cnt;
  logic       op;
  logic [30:0] dt;
  logic signed [31:0] init_pos_x, init_pos_y, init_vel_x, init_vel_y;
  logic [30:0] gravity, central_mass;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y, ax, ay;
  logic [47:0] gm;
  logic [63:0] prod, acc, g, dq, rad, pe;
  logic [31:0] drem, root;
  logic [33:0] srem;
  logic signed [31:0] energy;
  logic singular, energy_phase, axis;
  logic [31:0] mul_a, mul_b;
  logic res_fire;

  // Shared datapath combinational terms.
  logic [32:0] div_sh;
  logic        div_ge;
  logic [35:0] sq_sh, sq_trial;
  logic        sq_ge;
  logic [64:0] msum;
  logic        msat;
  logic [63:0] ke_sum, ke;
  logic [31:0] axis_mag;

  assign cmd_stall = (state != ST_IDLE);
  assign res_fire  = (state == ST_FIN) && (!res_valid || !res_stall);
  assign axis_mag  = axis ? mag32(pos_y) : mag32(pos_x);

  assign div_sh  = {drem, dq[63]};
  assign div_ge  = (div_sh >= {1'b0, root});
  assign sq_sh   = {srem, rad[63:62]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ge   = (sq_sh >= sq_trial);
  assign msum    = {1'b0, acc[31:0], 32'd0} + {1'b0, prod};
  assign msat    = (|acc[63:32]) || msum[64];
  assign ke_sum  = acc + prod;
  assign ke      = {{(FRAC_BITS + 1){1'b0}}, ke_sum[63:FRAC_BITS+1]};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (cmd_valid) state_next = ST_GM;
      ST_GM:    state_next = ST_GMSV;
      ST_GMSV:  state_next = ST_RSQX;
      ST_RSQX:  state_next = ST_RSQY;
      ST_RSQY:  state_next = ST_RSUM;
      ST_RSUM:  state_next = ST_SQRT;
      ST_SQRT:  if (cnt == SQRT_LAST) state_next = ST_RDONE;
      ST_RDONE: begin
        if (root == 32'd0) state_next = energy_phase ? ST_KEX : ST_UPX;
        else state_next = ST_DIV;
      end
      ST_DIV:   if (cnt == DIV_LAST) state_next = div_ret;
      ST_G2:    state_next = ST_DIV;
      ST_GSV:   state_next = ST_MH;
      ST_MH:    state_next = ST_ML;
      ST_ML:    state_next = ST_MS;
      ST_MS:    state_next = ST_DIV;
      ST_MW:    state_next = axis ? ST_UPX : ST_MH;
      ST_UPX:   state_next = ST_UPXW;
      ST_UPXW:  state_next = ST_UPYW;
      ST_UPYW:  state_next = ST_UVXW;
      ST_UVXW:  state_next = ST_UVYW;
      ST_UVYW:  state_next = ST_RSQX;
      ST_PEW:   state_next = ST_KEX;
      ST_KEX:   state_next = ST_KEY;
      ST_KEY:   state_next = ST_KES;
      ST_KES:   state_next = ST_FIN;
      ST_FIN:   if (res_fire) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state)
      ST_GM:   begin mul_a = {1'b0, gravity}; mul_b = {1'b0, central_mass}; end
      ST_RSQX: begin mul_a = mag32(pos_x); mul_b = mag32(pos_x); end
      ST_RSQY: begin mul_a = mag32(pos_y); mul_b = mag32(pos_y); end
      ST_MH:   begin mul_a = g[63:32]; mul_b = axis_mag; end
      ST_ML:   begin mul_a = g[31:0]; mul_b = axis_mag; end
      ST_UPX:  begin mul_a = mag32(vel_x); mul_b = {1'b0, dt}; end
      ST_UPXW: begin mul_a = mag32(vel_y); mul_b = {1'b0, dt}; end
      ST_UPYW: begin mul_a = mag32(ax); mul_b = {1'b0, dt}; end
      ST_UVXW: begin mul_a = mag32(ay); mul_b = {1'b0, dt}; end
      ST_KEX:  begin mul_a = mag32(vel_x); mul_b = mag32(vel_x); end
      ST_KEY:  begin mul_a = mag32(vel_y); mul_b = mag32(vel_y); end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end

  // Control state, configuration registers and orbit state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      res_valid    <= 1'b0;
      init_pos_x   <= ONE;
      init_pos_y   <= 32'sd0;
      init_vel_x   <= 32'sd0;
      init_vel_y   <= ONE;
      gravity      <= ONE[30:0];
      central_mass <= ONE[30:0];
      pos_x        <= ONE;
      pos_y        <= 32'sd0;
      vel_x        <= 32'sd0;
      vel_y        <= ONE;
    end else begin
      state <= state_next;
      if (res_fire) res_valid <= 1'b1;
      else if (res_valid && !res_stall) res_valid <= 1'b0;

      if (cfg_write) begin
        case (cfg_index)
          REG_INIT_POS_X:   init_pos_x   <= cfg_data;
          REG_INIT_POS_Y:   init_pos_y   <= cfg_data;
          REG_INIT_VEL_X:   init_vel_x   <= cfg_data;
          REG_INIT_VEL_Y:   init_vel_y   <= cfg_data;
          REG_GRAVITY:      gravity      <= cfg_data[30:0];
          REG_CENTRAL_MASS: central_mass <= cfg_data[30:0];
          default: ;
        endcase
      end

      // State updates: reload, then the four Euler updates.
      case (state)
        ST_GMSV: begin
          if (op == OP_RELOAD) begin
            pos_x <= init_pos_x;
            pos_y <= init_pos_y;
            vel_x <= init_vel_x;
            vel_y <= init_vel_y;
          end
        end
        ST_UPXW: pos_x <= sadd(pos_x, to_word(vel_x[31],
                           {{FRAC_BITS{1'b0}}, prod[63:FRAC_BITS]}));
        ST_UPYW: pos_y <= sadd(pos_y, to_word(vel_y[31],
                           {{FRAC_BITS{1'b0}}, prod[63:FRAC_BITS]}));
        ST_UVXW: vel_x <= sadd(vel_x, to_word(ax[31],
                           {{FRAC_BITS{1'b0}}, prod[63:FRAC_BITS]}));
        ST_UVYW: vel_y <= sadd(vel_y, to_word(ay[31],
                           {{FRAC_BITS{1'b0}}, prod[63:FRAC_BITS]}));
        default: ;
      endcase
    end
  end

  // Shared multiplier, divider, square root and working registers.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          op       <= cmd.opcode;
          dt       <= cmd.time_step;
          singular <= 1'b0;
        end
      end
      ST_GMSV: begin
        gm           <= prod[63:FRAC_BITS];
        energy_phase <= op;
      end
      ST_RSQY: acc <= prod;
      ST_RSUM: begin
        rad  <= acc + prod;
        srem <= 34'd0;
        root <= 32'd0;
        cnt  <= 6'd0;
      end
      ST_SQRT: begin
        srem <= sq_ge ? 34'(sq_sh - sq_trial) : sq_sh[33:0];
        root <= {root[30:0], sq_ge};
        rad  <= {rad[61:0], 2'b00};
        cnt  <= cnt + 6'd1;
      end
      ST_RDONE: begin
        if (root == 32'd0) begin
          singular <= 1'b1;
          ax <= 32'sd0;
          ay <= 32'sd0;
          pe <= 64'd0;
        end else begin
          dq      <= {gm, {FRAC_BITS{1'b0}}};
          drem    <= 32'd0;
          cnt     <= 6'd0;
          div_ret <= energy_phase ? ST_PEW : ST_G2;
        end
      end
      ST_DIV: begin
        drem <= div_ge ? 32'(div_sh - {1'b0, root}) : div_sh[31:0];
        dq   <= {dq[62:0], div_ge};
        cnt  <= cnt + 6'd1;
      end
      ST_G2: begin
        dq      <= (|dq[63:64-FRAC_BITS]) ? {64{1'b1}} : {dq[63-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        drem    <= 32'd0;
        cnt     <= 6'd0;
        div_ret <= ST_GSV;
      end
      ST_GSV: begin
        g    <= dq;
        axis <= 1'b0;
      end
      ST_ML: acc <= prod;
      ST_MS: begin
        dq      <= msat ? {64{1'b1}} : msum[63:0];
        drem    <= 32'd0;
        cnt     <= 6'd0;
        div_ret <= ST_MW;
      end
      ST_MW: begin
        if (!axis) begin
          ax   <= to_word(!pos_x[31] && (pos_x != 32'sd0), dq);
          axis <= 1'b1;
        end else begin
          ay <= to_word(!pos_y[31] && (pos_y != 32'sd0), dq);
        end
      end
      ST_UVYW: energy_phase <= 1'b1;
      ST_PEW: pe <= dq;
      ST_KEY: acc <= prod;
      ST_KES: energy <= (ke >= pe) ? to_word(1'b0, ke - pe) : to_word(1'b1, pe - ke);
      ST_FIN: begin
        if (res_fire) begin
          res.pos_x_out  <= pos_x;
          res.pos_y_out  <= pos_y;
          res.vel_x_out  <= vel_x;
          res.vel_y_out  <= vel_y;
          res.energy_out <= energy;
          res.singular   <= singular;
        end
      end
      default: ;
    endcase
  end

  // A new request always starts with the gravity product.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> (state == ST_GM))
    else $error("request did not start the sequencer");

  // The divider leaves its state after the last quotient bit.
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt == DIV_LAST) |=> (state != ST_DIV))
    else $error("divider overran its bit count");

  // The square root always ends in the radius check.
  a_sqrt_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT && cnt == SQRT_LAST) |=> (state == ST_RDONE))
    else $error("square root did not hand over");

  // A finished item with a free output register shows up as a result.
  a_fin: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !res_valid) |=> res_valid)
    else $error("result not presented");

endmodule
